/* rtl/core/iol_pkg.sv */
// Package with shared constants, codes and types of the indexed ordered list.
`default_nettype none

package iol_pkg;

    // Number of cells in the chain (range 2 to 4096).
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int DATA_W   = 32;
    localparam int POS_W    = 16;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Cell operations broadcast along the chain.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    // Configuration register index.
    localparam logic REG_ELEMENT_IS_CHAR = 1'b0;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  rd_pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/iol_in_if.sv */
// Request channel interface: operation item with valid/ready handshake.
`default_nettype none

interface iol_in_if;
    logic                                valid;
    logic                                ready;
    logic        [iol_pkg::MODE_W-1:0]   mode;
    logic signed [iol_pkg::POS_W-1:0]    position;
    logic signed [iol_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/iol_out_if.sv */
// Result channel interface: result item with valid/ready handshake.
`default_nettype none

interface iol_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [iol_pkg::DATA_W-1:0]   read_value;
    logic        [iol_pkg::STAT_W-1:0]   status;
    logic        [iol_pkg::CNT_W-1:0]    length;
    logic                                is_empty;

    modport source (output valid, output read_value, output status, output length,
                    output is_empty, input ready);
    modport sink   (input valid, input read_value, input status, input length,
                    input is_empty, output ready);
endinterface

`default_nettype wire

/* rtl/core/indexed_ordered_list_top.sv */
// Top level of the indexed ordered list: register port, cell chain and controller.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements in a
// chain of cells. Each item on the request channel i_req carries an operation
// (append, remove last, insert, erase, lenient read, checked read, clear), a
// position and a value. For every item exactly one result item leaves on o_rsp
// with the value read, a status code, the new length and an empty flag.
// An item is taken at a clock edge where valid and ready are both high. Every
// operation completes in the cycle it is taken: all cells shift together, so an
// insert or erase moves every element at once, and a read selects one cell.
// The result is registered and appears in the cycle after the item is taken.
// One item per cycle is sustained; the only limit is the result register.
// If the receiver stalls, the result is held and i_req.ready drops until it
// is taken; one item can be taken in the very cycle the held result leaves.
// The APB port holds the element_is_char register at byte address 0; writes
// should happen while no item is in flight.
// Synchronous active-low reset empties the list and clears element_is_char;
// cell contents are not cleared since only cells below the length are read.
`default_nettype none

module indexed_ordered_list_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    iol_in_if.sink                        i_req,
    iol_out_if.source                     o_rsp,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [2:0]                     paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Character mode register.
    logic r_is_char;

    // Data of every cell, and each cell's contribution to the read path.
    logic [iol_pkg::DATA_W-1:0] w_data    [iol_pkg::CAPACITY];
    logic [iol_pkg::DATA_W-1:0] w_rd_part [iol_pkg::CAPACITY];
    logic [iol_pkg::DATA_W-1:0] w_rd_data;

    // Operation broadcast from the controller to all cells.
    iol_pkg::t_cell_ctl w_ctl;

    assign pready = 1'b1;

    // The register is written on the access phase of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_char <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == iol_pkg::REG_ELEMENT_IS_CHAR) begin
            r_is_char <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == iol_pkg::REG_ELEMENT_IS_CHAR) ? {31'd0, r_is_char} : '0;

    // The cell chain. Each cell sees its lower and upper neighbor; the ends
    // see zero, which only ever enters a cell at or above the length.
    for (genvar gi = 0; gi < iol_pkg::CAPACITY; gi++) begin : g_cell
        logic [iol_pkg::DATA_W-1:0] w_left;
        logic [iol_pkg::DATA_W-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end

        if (gi == iol_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end

        iol_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_index   (iol_pkg::IDX_W'(gi)),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[gi]),
            .o_rd_data (w_rd_part[gi])
        );
    end

    // Only the selected cell drives nonzero data, so the read is an OR of all.
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < iol_pkg::CAPACITY; k++) begin
            w_rd_data = w_rd_data | w_rd_part[k];
        end
    end

    iol_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_is_char (r_is_char),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_rd_data (w_rd_data),
        .o_ctl     (w_ctl)
    );

endmodule

`default_nettype wire

/* rtl/core/iol_cell.sv */
// One storage cell of the list chain: holds one element, shifts with its neighbors.
`default_nettype none

module iol_cell (
    input  wire                           i_clk,
    input  iol_pkg::t_cell_ctl            i_ctl,
    input  wire [iol_pkg::IDX_W-1:0]      i_index,
    input  wire [iol_pkg::DATA_W-1:0]     i_left,
    input  wire [iol_pkg::DATA_W-1:0]     i_right,
    output logic [iol_pkg::DATA_W-1:0]    o_data,
    output logic [iol_pkg::DATA_W-1:0]    o_rd_data
);

    logic [iol_pkg::DATA_W-1:0] r_data;
    logic [iol_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            iol_pkg::CELL_INS: begin
                // Cells above the insert point take their lower neighbor.
                if (i_index > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_index == i_ctl.pos) begin
                    n_data = i_ctl.wdata;
                end
            end
            iol_pkg::CELL_DEL: begin
                // Cells at and above the erase point take their upper neighbor.
                if (i_index >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = (i_index == i_ctl.rd_pos) ? r_data : '0;

endmodule

`default_nettype wire

/* rtl/core/iol_ctrl.sv */
// List controller: decodes operations, keeps the element count, registers results.
`default_nettype none

module iol_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_is_char,
    iol_in_if.sink                           i_req,
    iol_out_if.source                        o_rsp,
    input  wire [iol_pkg::DATA_W-1:0]        i_rd_data,
    output iol_pkg::t_cell_ctl               o_ctl
);

    logic                         r_out_valid;
    logic [iol_pkg::CNT_W-1:0]    r_count;
    logic [iol_pkg::DATA_W-1:0]   r_read_value;
    logic [iol_pkg::STAT_W-1:0]   r_status;
    logic [iol_pkg::CNT_W-1:0]    r_length;
    logic                         r_is_empty;

    logic [iol_pkg::CNT_W-1:0]    n_count;
    logic [iol_pkg::DATA_W-1:0]   n_read_value;
    logic [iol_pkg::STAT_W-1:0]   n_status;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_pos_neg;
    logic                         w_pos_le0;
    logic                         w_pos_ge_n;
    logic [iol_pkg::IDX_W-1:0]    w_pos_idx;
    logic [iol_pkg::IDX_W-1:0]    w_cnt_idx;
    logic [iol_pkg::DATA_W-1:0]   w_stored;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full     = (r_count == iol_pkg::CNT_W'(iol_pkg::CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_pos_neg  = i_req.position[iol_pkg::POS_W-1];
    assign w_pos_le0  = w_pos_neg || (i_req.position == '0);
    // The count is narrower than the position, so zero-extending keeps it positive.
    assign w_pos_ge_n = (i_req.position >= $signed(iol_pkg::POS_W'(r_count)));
    assign w_pos_idx  = i_req.position[iol_pkg::IDX_W-1:0];
    assign w_cnt_idx  = r_count[iol_pkg::IDX_W-1:0];
    assign w_stored   = i_is_char ? {{(iol_pkg::DATA_W-8){i_req.value[7]}}, i_req.value[7:0]}
                                  : i_req.value;

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = iol_pkg::ST_OK;
        o_ctl.op     = iol_pkg::CELL_HOLD;
        o_ctl.pos    = w_cnt_idx;
        o_ctl.wdata  = w_stored;
        o_ctl.rd_pos = w_pos_neg ? '0 : w_pos_idx;
        case (i_req.mode)
            iol_pkg::MODE_PUSH, iol_pkg::MODE_INSERT: begin
                if (w_full) begin
                    n_status = iol_pkg::ST_FULL;
                end else begin
                    o_ctl.op = iol_pkg::CELL_INS;
                    if (i_req.mode == iol_pkg::MODE_PUSH || w_pos_ge_n) begin
                        o_ctl.pos = w_cnt_idx;
                    end else if (w_pos_le0) begin
                        o_ctl.pos = '0;
                    end else begin
                        o_ctl.pos = w_pos_idx;
                    end
                    n_count = r_count + 1'b1;
                end
            end
            iol_pkg::MODE_POP: begin
                if (w_empty) begin
                    n_status = iol_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            iol_pkg::MODE_ERASE: begin
                if (!w_empty && !w_pos_ge_n) begin
                    o_ctl.op  = iol_pkg::CELL_DEL;
                    o_ctl.pos = w_pos_neg ? '0 : w_pos_idx;
                    n_count   = r_count - 1'b1;
                end
            end
            iol_pkg::MODE_READ: begin
                n_read_value = (w_empty || w_pos_ge_n) ? '1 : i_rd_data;
            end
            iol_pkg::MODE_CHECK: begin
                if (w_pos_neg || w_pos_ge_n) begin
                    n_read_value = '1;
                    n_status     = iol_pkg::ST_RANGE;
                end else begin
                    n_read_value = i_rd_data;
                end
            end
            iol_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // Cells move only on the edge that takes the item.
        if (!w_accept) begin
            o_ctl.op = iol_pkg::CELL_HOLD;
            n_count  = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_length     <= n_count;
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.length     = r_length;
    assign o_rsp.is_empty   = r_is_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iol_pkg::CNT_W'(iol_pkg::CAPACITY))
        else $error("element count above capacity");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("element count changed without an item");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_is_empty == (r_length == '0)))
        else $error("empty flag disagrees with length");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.mode == iol_pkg::MODE_CLEAR |=> r_count == '0 && r_is_empty)
        else $error("clear left elements behind");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full &&
        (i_req.mode == iol_pkg::MODE_PUSH || i_req.mode == iol_pkg::MODE_INSERT)
        |=> r_status == iol_pkg::ST_FULL && $stable(r_count))
        else $error("write to full list not dropped");

endmodule

`default_nettype wire

/* verif/tb_indexed_ordered_list_top.sv */
// Self-checking testbench for the indexed ordered list top level.
`timescale 1ns / 1ps

module tb_indexed_ordered_list_top;

    // Mode 7 has no operation; the block must report it as a plain ok.
    localparam logic [iol_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic [2:0] ADDR_ELEMENT_IS_CHAR = {iol_pkg::REG_ELEMENT_IS_CHAR, 2'b00};

    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 8;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef enum {MIX_BALANCED, MIX_GROW, MIX_SHRINK} t_op_mix;

    typedef struct packed {
        logic signed [iol_pkg::DATA_W-1:0] read_value;
        logic [iol_pkg::STAT_W-1:0]        status;
        logic [iol_pkg::CNT_W-1:0]         length;
        logic                              is_empty;
    } t_list_rsp;

    // Mirror of the list contents; computes the result of every accepted
    // item and checks result items against them in order.
    class list_tracker;
        logic [iol_pkg::DATA_W-1:0] cells [iol_pkg::CAPACITY];
        int                         count;
        bit                         char_mode;
        t_list_rsp                  expected_q [$];
        int                         errors;

        function new();
            count     = 0;
            char_mode = 0;
            errors    = 0;
        endfunction

        function void set_char_mode(bit m);
            char_mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_op(logic [iol_pkg::MODE_W-1:0] mode,
                               logic signed [iol_pkg::POS_W-1:0] pos,
                               logic signed [iol_pkg::DATA_W-1:0] value);
            t_list_rsp                  r;
            int                         n;
            int                         p;
            int                         ipos;
            logic [iol_pkg::DATA_W-1:0] stored;

            n            = count;
            ipos         = pos;
            r.read_value = '0;
            r.status     = iol_pkg::ST_OK;
            stored = char_mode ? {{24{value[7]}}, value[7:0]} : value;
            case (mode)
                iol_pkg::MODE_PUSH, iol_pkg::MODE_INSERT: begin
                    if (n >= iol_pkg::CAPACITY) begin
                        r.status = iol_pkg::ST_FULL;
                    end else begin
                        // Lenient placement: below the front inserts first,
                        // past the end appends.
                        if (mode == iol_pkg::MODE_PUSH || ipos >= n) p = n;
                        else if (ipos <= 0) p = 0;
                        else p = ipos;
                        for (int i = n; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = stored;
                        count = n + 1;
                    end
                end
                iol_pkg::MODE_POP: begin
                    if (n == 0) r.status = iol_pkg::ST_EMPTY;
                    else count = n - 1;
                end
                iol_pkg::MODE_ERASE: begin
                    // A negative position erases the head; past the end is ignored.
                    if (n != 0 && ipos < n) begin
                        p = (ipos < 0) ? 0 : ipos;
                        for (int i = p; i + 1 < n; i++) cells[i] = cells[i+1];
                        count = n - 1;
                    end
                end
                iol_pkg::MODE_READ: begin
                    if (n == 0 || ipos >= n) r.read_value = -1;
                    else r.read_value = cells[(ipos < 0) ? 0 : ipos];
                end
                iol_pkg::MODE_CHECK: begin
                    if (ipos < 0 || ipos >= n) begin
                        r.read_value = -1;
                        r.status     = iol_pkg::ST_RANGE;
                    end else begin
                        r.read_value = cells[ipos];
                    end
                end
                iol_pkg::MODE_CLEAR: count = 0;
                default: ;
            endcase
            r.length   = iol_pkg::CNT_W'(count);
            r.is_empty = (count == 0);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_response(logic signed [iol_pkg::DATA_W-1:0] rd,
                                     logic [iol_pkg::STAT_W-1:0] st,
                                     logic [iol_pkg::CNT_W-1:0] len, logic emp);
            t_list_rsp e;

            if (expected_q.size() == 0) begin
                $error("result item with no request outstanding: read_value %0d status %0d",
                       rd, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rd !== e.read_value) begin
                $error("read_value: expected %0d, got %0d", e.read_value, rd);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (len !== e.length) begin
                $error("length: expected %0d, got %0d", e.length, len);
                errors++;
            end
            if (emp !== e.is_empty) begin
                $error("is_empty: expected %0b, got %0b", e.is_empty, emp);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iol_in_if  req_if ();
    iol_out_if rsp_if ();

    indexed_ordered_list_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    list_tracker tracker = new();

    // Idling knobs, in percent per cycle, set by the stimulus per phase.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    // Cycles of forced back-pressure still to come, consumed by the receiver.
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks each accepted result item, then decides ready for the
    // next cycle from the stall rate or a pending hold-off stretch.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                tracker.check_response(rsp_if.read_value, rsp_if.status, rsp_if.length,
                                       rsp_if.is_empty);
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Watchdog: the run is stuck when neither channel moves an item for too long.
    initial begin
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("indexed_ordered_list_top regression: fail");
        $finish;
    end

    // Offers one item, with random idle cycles ahead of it, and records it in
    // the tracker at the edge where it is taken. Valid stays high on return.
    task automatic send_item(logic [iol_pkg::MODE_W-1:0] mode,
                             logic signed [iol_pkg::POS_W-1:0] pos,
                             logic signed [iol_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.position <= pos;
        req_if.value    <= value;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.apply_op(mode, pos, value);
    endtask

    // Lets every outstanding result drain, then writes the character-mode
    // register through a setup and an access cycle.
    task automatic set_element_mode(bit char_mode);
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ELEMENT_IS_CHAR;
        pwdata  <= {31'd0, char_mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_char_mode(char_mode);
    endtask

    function automatic logic [iol_pkg::MODE_W-1:0] pick_mode(t_op_mix mix);
        int r;

        r = $urandom_range(99);
        case (mix)
            MIX_GROW: begin
                if (r < 45) return iol_pkg::MODE_PUSH;
                if (r < 80) return iol_pkg::MODE_INSERT;
                if (r < 85) return iol_pkg::MODE_POP;
                if (r < 90) return iol_pkg::MODE_ERASE;
                if (r < 95) return iol_pkg::MODE_READ;
                return iol_pkg::MODE_CHECK;
            end
            MIX_SHRINK: begin
                if (r < 12) return iol_pkg::MODE_PUSH;
                if (r < 24) return iol_pkg::MODE_INSERT;
                if (r < 45) return iol_pkg::MODE_POP;
                if (r < 70) return iol_pkg::MODE_ERASE;
                if (r < 82) return iol_pkg::MODE_READ;
                if (r < 94) return iol_pkg::MODE_CHECK;
                if (r < 97) return iol_pkg::MODE_CLEAR;
                return MODE_UNUSED;
            end
            default: begin
                if (r < 22) return iol_pkg::MODE_PUSH;
                if (r < 40) return iol_pkg::MODE_INSERT;
                if (r < 52) return iol_pkg::MODE_POP;
                if (r < 64) return iol_pkg::MODE_ERASE;
                if (r < 78) return iol_pkg::MODE_READ;
                if (r < 92) return iol_pkg::MODE_CHECK;
                if (r < 96) return iol_pkg::MODE_CLEAR;
                return MODE_UNUSED;
            end
        endcase
    endfunction

    // Mostly positions around the live range, some anywhere in the field,
    // and some on the boundaries where the lenient rules kick in.
    function automatic logic signed [iol_pkg::POS_W-1:0] pick_position(int n);
        int r;
        int p;

        r = $urandom_range(99);
        if (r < 70) begin
            p = $urandom_range(n + 2);
            p = p - 2;
            return p[iol_pkg::POS_W-1:0];
        end
        if (r < 85) return iol_pkg::POS_W'($urandom_range(16'hFFFF));
        case ($urandom_range(5))
            0: p = n - 1;
            1: p = n;
            2: p = 0;
            3: p = -1;
            4: p = 32767;
            default: p = -32768;
        endcase
        return p[iol_pkg::POS_W-1:0];
    endfunction

    function automatic logic signed [iol_pkg::DATA_W-1:0] pick_value();
        int r;

        r = $urandom_range(99);
        if (r < 50) return $urandom;
        if (r < 75) return $urandom_range(255) - 128;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return -1;
            default: return {24'($urandom_range(32'hFF_FFFF)), 1'b1,
                             7'($urandom_range(127))};
        endcase
    endfunction

    initial begin
        t_op_mix mix;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.mode     = iol_pkg::MODE_PUSH;
        req_if.position = '0;
        req_if.value    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-list corner cases, field extremes, the lenient
        // and checked boundaries, then character mode.
        set_element_mode(1'b0);
        send_item(iol_pkg::MODE_CHECK,  16'sd0,      32'sd0);
        send_item(iol_pkg::MODE_READ,   -16'sd1,     32'sd0);
        send_item(iol_pkg::MODE_POP,    16'sd0,      32'sd0);
        send_item(iol_pkg::MODE_ERASE,  -16'sd5,     32'sd0);
        send_item(iol_pkg::MODE_PUSH,   16'sd0,      32'h7FFF_FFFF);
        send_item(iol_pkg::MODE_PUSH,   16'sd0,      32'h8000_0000);
        send_item(iol_pkg::MODE_INSERT, -16'sd32768, 32'sd0);
        send_item(iol_pkg::MODE_INSERT, 16'sd32767,  -32'sd1);
        send_item(iol_pkg::MODE_INSERT, 16'sd2,      32'h1234_5680);
        send_item(iol_pkg::MODE_READ,   -16'sd32768, 32'sd0);
        send_item(iol_pkg::MODE_READ,   16'sd32767,  32'sd0);
        send_item(iol_pkg::MODE_READ,   16'sd4,      32'sd0);
        send_item(iol_pkg::MODE_CHECK,  -16'sd1,     32'sd0);
        send_item(iol_pkg::MODE_CHECK,  16'sd5,      32'sd0);
        send_item(iol_pkg::MODE_CHECK,  16'sd2,      32'sd0);
        send_item(iol_pkg::MODE_ERASE,  16'sd32767,  32'sd0);
        send_item(iol_pkg::MODE_ERASE,  -16'sd1,     32'sd0);
        send_item(iol_pkg::MODE_ERASE,  16'sd1,      32'sd0);
        send_item(MODE_UNUSED,          16'sd3,      32'h5A5A_A5A5);
        send_item(iol_pkg::MODE_POP,    16'sd0,      32'sd0);
        send_item(iol_pkg::MODE_CLEAR,  16'sd0,      32'sd0);
        send_item(iol_pkg::MODE_READ,   16'sd0,      32'sd0);
        set_element_mode(1'b1);
        send_item(iol_pkg::MODE_PUSH,   16'sd0,      32'h0000_00FF);
        send_item(iol_pkg::MODE_PUSH,   16'sd0,      32'h1234_5678);
        send_item(iol_pkg::MODE_CHECK,  16'sd0,      32'sd0);
        send_item(iol_pkg::MODE_READ,   16'sd1,      32'sd0);

        // Random phases: each pairs an idling pattern with a character mode and
        // an operation mix. The growing mix pins the list at capacity so the
        // full-store path is exercised repeatedly.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_element_mode(((ph % 2) != 0) ^ ((ph / 4) != 0));
            case (ph % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
                default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
            endcase
            case (ph % 3)
                0: mix = MIX_BALANCED;
                1: mix = MIX_GROW;
                default: mix = MIX_SHRINK;
            endcase
            // A long receiver hold-off while items keep coming fills the
            // result register and must stall the request channel.
            if (ph == 0) hold_left = HOLD_OFF_CYCLES;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_item(pick_mode(mix), pick_position(tracker.count), pick_value());
            end
        end

        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("indexed_ordered_list_top regression: pass");
        end else begin
            $display("indexed_ordered_list_top regression: fail");
        end
        $finish;
    end

endmodule
